@@ rtl/core/assert_macros.svh @@
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define CHTE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication
`define CHTE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ rtl/core/chte_pkg.sv @@
// ----------------------------------------------------------------------------
// chte_pkg
// Types and codes shared by the chunk hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;

	localparam logic [1:0] REQ_PLACE  = 2'd0;
	localparam logic [1:0] REQ_CREATE = 2'd1;
	localparam logic [1:0] REQ_LOOKUP = 2'd2;

	localparam logic [2:0] ST_FOUND      = 3'd0;
	localparam logic [2:0] ST_CREATED    = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
	localparam logic [2:0] ST_POOL_EMPTY = 3'd3;
	localparam logic [2:0] ST_LIST_FULL  = 3'd4;

	localparam int unsigned HASH_X = 19;
	localparam int unsigned HASH_Y = 32;
	localparam int unsigned HASH_Z = 7;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] chunk_x;
		logic signed [31:0] chunk_y;
		logic signed [31:0] chunk_z;
		logic [15:0]        entity_id;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [8:0] entry_index;
		logic [4:0] entity_count;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request, compute hash
		logic rd_home;   // read entry at home bucket
		logic rd_link;   // read entry at link
		logic claim;     // write key at current node
		logic alloc;     // allocate pool node, link it
		logic append;    // write entity, bump count
		logic clr_pass;  // write reset value at clear pointer
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic match;
		logic cnt_zero;
		logic link_end;
		logic pool_full;
		logic list_full;
		logic may_create;
		logic is_place;
		logic clr_done;
	} sts_t;

endpackage

@@ rtl/core/chte_ram.sv @@
// ----------------------------------------------------------------------------
// chte_ram
// Single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/chte_datapath.sv @@
// ----------------------------------------------------------------------------
// chte_datapath
// Hash, entry memories, pool allocator and result formation.
// ----------------------------------------------------------------------------
module chte_datapath #(
	parameter int BUCKETS            = 256,
	parameter int POOL_NODES         = 256,
	parameter int ENTITIES_PER_CHUNK = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  chte_pkg::req_t   req,
	input  chte_pkg::cmd_t   cmd,
	output chte_pkg::sts_t   sts,
	output logic [8:0]       node_index,
	output logic [4:0]       node_count
);

	localparam int TOTAL = BUCKETS + POOL_NODES;
	localparam int AW    = $clog2(TOTAL);
	localparam int BW    = $clog2(BUCKETS);
	localparam int PW    = $clog2(POOL_NODES + 1);
	localparam int CW    = $clog2(ENTITIES_PER_CHUNK + 1);
	localparam int SW    = $clog2(ENTITIES_PER_CHUNK);
	localparam int EW    = (SW > 0) ? AW + SW : AW;
	localparam int KW    = 96;

	chte_pkg::req_t  req_q;
	logic [AW-1:0]   node_q;
	logic [AW-1:0]   clr_q;
	logic [PW-1:0]   pool_used_q;
	logic [31:0]     hash;

	// entry record: key, count, link
	logic [KW-1:0]   key_rd, key_wd;
	logic [CW-1:0]   cnt_rd, cnt_wd;
	logic [AW:0]     lnk_rd, lnk_wd;
	logic            key_we, cnt_we, lnk_we;
	logic [AW-1:0]   key_wa, cnt_wa, lnk_wa, rd_a;
	logic [AW-1:0]   fresh;
	logic [EW-1:0]   ent_wa;
	logic [15:0]     ent_rd;

	assign hash = (req_q.chunk_x * 32'(chte_pkg::HASH_X))
		+ (req_q.chunk_y << 5) + (req_q.chunk_z * 32'(chte_pkg::HASH_Z));
	assign fresh = AW'(BUCKETS) + AW'(pool_used_q);

	always_comb begin
		if (cmd.rd_home) begin
			rd_a = AW'(hash[BW-1:0]);
		end else if (cmd.rd_link) begin
			rd_a = lnk_rd[AW-1:0];
		end else begin
			rd_a = node_q;
		end
	end

	always_comb begin
		key_we = 1'b0; cnt_we = 1'b0; lnk_we = 1'b0;
		key_wa = node_q; cnt_wa = node_q; lnk_wa = node_q;
		key_wd = {req_q.chunk_x, req_q.chunk_y, req_q.chunk_z};
		cnt_wd = cnt_rd + CW'(1);
		lnk_wd = '0;
		if (cmd.clr_pass) begin
			key_we = 1'b1; cnt_we = 1'b1; lnk_we = 1'b1;
			key_wa = clr_q; cnt_wa = clr_q; lnk_wa = clr_q;
			key_wd = '0; cnt_wd = '0;
		end else if (cmd.claim) begin
			key_we = 1'b1;
		end else if (cmd.alloc) begin
			key_we = 1'b1; key_wa = fresh;
			cnt_we = 1'b1; cnt_wa = fresh; cnt_wd = '0;
			lnk_we = 1'b1; lnk_wd = (AW+1)'(fresh);
		end else if (cmd.append) begin
			cnt_we = 1'b1;
		end
	end

	chte_ram #(.WIDTH(KW), .DEPTH(TOTAL)) u_key (
		.clk(clk), .we(key_we), .waddr(key_wa), .wdata(key_wd),
		.raddr(rd_a), .rdata(key_rd));
	chte_ram #(.WIDTH(CW), .DEPTH(TOTAL)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd),
		.raddr(rd_a), .rdata(cnt_rd));
	chte_ram #(.WIDTH(AW + 1), .DEPTH(TOTAL)) u_lnk (
		.clk(clk), .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd),
		.raddr(rd_a), .rdata(lnk_rd));

	generate
		if (SW > 0) begin : g_slot
			assign ent_wa = {node_q, cnt_rd[SW-1:0]};
		end else begin : g_noslot
			assign ent_wa = node_q;
		end
	endgenerate

	chte_ram #(.WIDTH(16), .DEPTH(TOTAL * ENTITIES_PER_CHUNK)) u_ent (
		.clk(clk), .we(cmd.append), .waddr(ent_wa), .wdata(req_q.entity_id),
		.raddr(ent_wa), .rdata(ent_rd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_used_q <= '0;
			clr_q       <= '0;
			node_q      <= '0;
		end else begin
			if (cmd.clr_pass) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.rd_home) begin
				node_q <= AW'(hash[BW-1:0]);
			end else if (cmd.rd_link) begin
				node_q <= lnk_rd[AW-1:0];
			end else if (cmd.alloc) begin
				node_q      <= fresh;
				pool_used_q <= pool_used_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	assign sts.match      = (key_rd == {req_q.chunk_x, req_q.chunk_y, req_q.chunk_z});
	assign sts.cnt_zero   = (cnt_rd == '0);
	assign sts.link_end   = (lnk_rd == '0) || (lnk_rd >= (AW+1)'(TOTAL));
	assign sts.pool_full  = (pool_used_q == PW'(POOL_NODES));
	assign sts.list_full  = (cnt_rd >= CW'(ENTITIES_PER_CHUNK));
	assign sts.may_create = !req_q.req_type[1];
	assign sts.is_place   = (req_q.req_type == chte_pkg::REQ_PLACE);
	assign sts.clr_done   = (clr_q == AW'(TOTAL - 1));

	assign node_index = 9'(node_q);
	assign node_count = 5'(cnt_rd);

endmodule

@@ rtl/core/chte_ctrl.sv @@
// ----------------------------------------------------------------------------
// chte_ctrl
// Sequencer: clearing pass, chain walk, claim, allocate, append, respond.
// ----------------------------------------------------------------------------
module chte_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	output chte_pkg::cmd_t   cmd,
	input  chte_pkg::sts_t   sts,
	input  logic [8:0]       node_index,
	input  logic [4:0]       node_count,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output chte_pkg::rsp_t   rsp
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HOME  = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_REREAD = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0] state_q, state_d;
	logic [2:0] stat_q, stat_d;
	logic       rsp_ld;
	logic [2:0] rsp_st;
	logic [8:0] rsp_ix;
	logic [4:0] rsp_ct;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		stat_d  = stat_q;
		cmd     = '0;
		rsp_ld  = 1'b0;
		rsp_st  = stat_q;
		rsp_ix  = node_index;
		rsp_ct  = node_count;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_pass = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_HOME;
				end
			end
			S_HOME: begin
				cmd.rd_home = 1'b1;
				state_d     = S_CHECK;
			end
			S_CHECK: begin
				priority if (sts.match) begin
					stat_d  = chte_pkg::ST_FOUND;
					state_d = S_FIN;
				end else if (sts.may_create && sts.cnt_zero) begin
					cmd.claim = 1'b1;
					stat_d    = chte_pkg::ST_CREATED;
					state_d   = S_FIN;
				end else if (!sts.link_end) begin
					cmd.rd_link = 1'b1;
				end else if (!sts.may_create) begin
					stat_d  = chte_pkg::ST_NOT_FOUND;
					state_d = S_OUT;
				end else if (sts.pool_full) begin
					stat_d  = chte_pkg::ST_POOL_EMPTY;
					state_d = S_OUT;
				end else begin
					cmd.alloc = 1'b1;
					stat_d    = chte_pkg::ST_CREATED;
					state_d   = S_REREAD;
				end
			end
			S_REREAD: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.is_place && sts.list_full) begin
					rsp_st = chte_pkg::ST_LIST_FULL;
				end else if (sts.is_place) begin
					cmd.append = 1'b1;
					rsp_ct     = node_count + 5'd1;
				end
				rsp_ld  = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!rsp_valid || !rsp_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (state_q == S_CHECK && state_d == S_OUT) begin
			rsp_ld = 1'b1;
			rsp_st = stat_d;
			rsp_ix = '0;
			rsp_ct = '0;
		end
	end

	// hold the result register until taken; S_OUT waits for it to drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			stat_q    <= chte_pkg::ST_FOUND;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			stat_q  <= stat_d;
			if (rsp_ld) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_ld) begin
			rsp.status       <= rsp_st;
			rsp.entry_index  <= rsp_ix;
			rsp.entity_count <= rsp_ct;
		end
	end

endmodule

@@ rtl/core/chunk_hash_table_engine.sv @@
// A request reads its home bucket and walks its chain with one entry read per node;
// allocating a pool node adds S_REREAD, while not found and pool exhausted skip S_FIN.
// A new request is taken only after the previous result has been transferred.
// Reset: async active low; a clearing pass over all BUCKETS+POOL_NODES entries follows.
// ----------------------------------------------------------------------------
// chunk_hash_table_engine
// Chained hash table of chunk coordinates with per-chunk entity lists.
// ----------------------------------------------------------------------------
module chunk_hash_table_engine #(
	parameter int BUCKETS            = 256,
	parameter int POOL_NODES         = 256,
	parameter int ENTITIES_PER_CHUNK = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  chte_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output chte_pkg::rsp_t  rsp
);

	chte_pkg::cmd_t cmd;
	chte_pkg::sts_t sts;
	logic [8:0]     node_index;
	logic [4:0]     node_count;

	chte_datapath #(
		.BUCKETS(BUCKETS), .POOL_NODES(POOL_NODES),
		.ENTITIES_PER_CHUNK(ENTITIES_PER_CHUNK)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .sts(sts),
		.node_index(node_index), .node_count(node_count));

	chte_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.cmd(cmd), .sts(sts), .node_index(node_index), .node_count(node_count),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp));

endmodule

@@ rtl/core/chte_checker.sv @@
// ----------------------------------------------------------------------------
// chte_checker
// Port-level checks for the chunk hash table engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chte_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_stall,
	input chte_pkg::req_t  req,
	input logic            rsp_valid,
	input logic            rsp_stall,
	input chte_pkg::rsp_t  rsp
);

	`CHTE_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result changed while stalled")
	`CHTE_ASSERT_IMP(a_status_range, clk, arst_n, rsp_valid, rsp.status <= chte_pkg::ST_LIST_FULL, "bad status")
	`CHTE_ASSERT_IMP(a_count_range, clk, arst_n, rsp_valid, rsp.entity_count <= 5'd16, "count out of range")
	`CHTE_ASSERT_IMP(a_miss_zero, clk, arst_n, rsp_valid && (rsp.status == chte_pkg::ST_NOT_FOUND || rsp.status == chte_pkg::ST_POOL_EMPTY), rsp.entry_index == 9'd0 && rsp.entity_count == 5'd0, "miss with nonzero payload")
	`CHTE_ASSERT_NXT(a_one_at_time, clk, arst_n, req_valid && !req_stall, req_stall, "second transfer taken during a request")

endmodule

bind chunk_hash_table_engine chte_checker u_chte_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
	.req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp));
